@@ rtl/page_bitmap_allocator_top_assert.svh @@
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while rst is high.
`ifndef PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page allocator check failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page allocator check failed");

`endif

@@ rtl/pba_pkg.sv @@
package pba_pkg;

  // request kinds passed from front to back
  localparam logic [1:0] KIND_RES   = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_BIG   = 2'd2;
  localparam logic [1:0] KIND_ZERO  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BIG = 2'd2;

  localparam int          PAGE_SHIFT = 12;
  localparam logic [31:0] PAGE_BYTES = 32'd4096;
  localparam logic [31:0] VIRT_BASE  = 32'hF000_0000;
  localparam logic [31:0] ONES       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } pba_head_t;

  // lowest set bit: {found, index}
  function automatic logic [5:0] pba_ffs(input logic [31:0] v);
    logic [4:0] idx;
    logic       found;
    idx   = 5'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx   = 5'(i);
        found = 1'b1;
      end
    end
    return {found, idx};
  endfunction

endpackage

@@ rtl/pba_ram.sv @@
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pba_front.sv @@
module pba_front import pba_pkg::*; #(
  parameter int NUM_PAGES = 32768,
  parameter int MAX_ALLOC_PAGES = 64,
  localparam int PW = $clog2(NUM_PAGES + 1),
  localparam int CW = $clog2(MAX_ALLOC_PAGES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          action,
  input  logic [31:0]   address,
  input  logic [31:0]   size,
  output logic          busy,
  input  logic          clearing,
  output pba_head_t     head,
  output logic [PW-1:0] head_lo,
  output logic [PW-1:0] head_hi,
  output logic [CW-1:0] head_cnt,
  input  logic          pop
);

  localparam int          QD = 2;
  localparam logic [21:0] NP = 22'(NUM_PAGES);

  logic [32:0]   size_up;
  logic [20:0]   npages;
  logic [21:0]   first;
  logic [21:0]   endp;
  logic [PW-1:0] lo_in;
  logic [PW-1:0] hi_in;
  logic [1:0]    kind_in;
  logic          push;

  logic [1:0]    q_kind [QD];
  logic [PW-1:0] q_lo   [QD];
  logic [PW-1:0] q_hi   [QD];
  logic [CW-1:0] q_cnt  [QD];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  // round out to whole pages and clamp the range to the bitmap
  always_comb begin
    size_up = {1'b0, size} + 33'd4095;
    npages  = size_up[32:12];
    first   = {2'b00, address[31:12]};
    endp    = first + {1'b0, npages};
    lo_in   = (first > NP) ? PW'(NP) : PW'(first);
    hi_in   = (endp > NP) ? PW'(NP) : PW'(endp);
    priority if (!action) begin
      kind_in = KIND_RES;
    end else if (npages > 21'(MAX_ALLOC_PAGES)) begin
      kind_in = KIND_BIG;
    end else if (npages == 21'd0) begin
      kind_in = KIND_ZERO;
    end else begin
      kind_in = KIND_ALLOC;
    end
  end

  assign busy = (count == 2'(QD)) || clearing;
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr] <= kind_in;
      q_lo[wr_ptr]   <= lo_in;
      q_hi[wr_ptr]   <= hi_in;
      q_cnt[wr_ptr]  <= CW'(npages);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.kind  = q_kind[rd_ptr];
  assign head_lo    = q_lo[rd_ptr];
  assign head_hi    = q_hi[rd_ptr];
  assign head_cnt   = q_cnt[rd_ptr];

endmodule

@@ rtl/pba_back.sv @@
module pba_back import pba_pkg::*; #(
  parameter int NUM_PAGES = 32768,
  parameter int MAX_ALLOC_PAGES = 64,
  localparam int PW = $clog2(NUM_PAGES + 1),
  localparam int CW = $clog2(MAX_ALLOC_PAGES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  pba_head_t     head,
  input  logic [PW-1:0] head_lo,
  input  logic [PW-1:0] head_hi,
  input  logic [CW-1:0] head_cnt,
  output logic          pop,
  output logic          clearing,
  output logic          strobe,
  output logic [31:0]   page_addr,
  output logic [31:0]   virt_addr,
  output logic [1:0]    status,
  output logic          last
);

  localparam int          WORDS     = (NUM_PAGES + 31) / 32;
  localparam int          AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int          LAST_BITS = NUM_PAGES - (WORDS - 1) * 32;
  localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF >> (32 - LAST_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [PW-1:0] NP      = PW'(NUM_PAGES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]    state, state_next;
  logic [PW-1:0] sc, sc_next;
  logic [31:0]   virt, virt_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [PW-1:0] lo, lo_next;
  logic [PW-1:0] hi_m1, hi_m1_next;
  logic [AW-1:0] wptr, wptr_next;
  logic [31:0]   word_reg, word_reg_next;
  logic          fresh, fresh_next;
  logic [AW-1:0] clr, clr_next;

  logic          strobe_next;
  logic [31:0]   phys_next;
  logic [31:0]   vout_next;
  logic [1:0]    status_next;
  logic          last_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [AW-1:0] sc_word;
  logic [31:0]   scan_src;
  logic [31:0]   cand;
  logic [5:0]    ffs;
  logic [PW-1:0] take_page;
  logic [AW-1:0] lo_word;
  logic [AW-1:0] hi_word;
  logic [31:0]   above;
  logic [31:0]   below;

  pba_ram #(
    .WIDTH(32),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign clearing = (state == S_CLEAR);
  assign pop      = head.valid && (state == S_IDLE);

  // word under the scan cursor, limited to pages at or past the cursor
  always_comb begin
    sc_word   = AW'(sc >> 5);
    scan_src  = fresh ? ram_rdata : word_reg;
    cand      = scan_src & (ONES << sc[4:0]) & ((sc_word == LAST_WORD) ? LAST_MASK : ONES);
    ffs       = pba_ffs(cand);
    take_page = PW'({sc_word, ffs[4:0]});
    lo_word   = AW'(lo >> 5);
    hi_word   = AW'(hi_m1 >> 5);
    above     = (wptr == lo_word) ? (ONES << lo[4:0]) : ONES;
    below     = (wptr == hi_word) ? (ONES >> (5'd31 - hi_m1[4:0])) : ONES;
  end

  always_comb begin
    state_next    = state;
    sc_next       = sc;
    virt_next     = virt;
    cnt_next      = cnt;
    lo_next       = lo;
    hi_m1_next    = hi_m1;
    wptr_next     = wptr;
    word_reg_next = word_reg;
    fresh_next    = fresh;
    clr_next      = clr;
    strobe_next   = 1'b0;
    phys_next     = 32'd0;
    vout_next     = 32'd0;
    status_next   = ST_OK;
    last_next     = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = wptr;
    ram_wdata     = ram_rdata & ~(above & below);
    ram_raddr     = wptr;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = ONES;
        clr_next  = clr + 1'b1;
        if (clr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.kind)
            KIND_RES: begin
              lo_next    = head_lo;
              hi_m1_next = head_hi - 1'b1;
              wptr_next  = AW'(head_lo >> 5);
              if (head_lo < head_hi) begin
                state_next = S_RD;
              end else begin
                strobe_next = 1'b1;
              end
            end
            KIND_BIG: begin
              strobe_next = 1'b1;
              status_next = ST_BIG;
            end
            KIND_ZERO: begin
              strobe_next = 1'b1;
              vout_next   = virt;
            end
            KIND_ALLOC: begin
              cnt_next = head_cnt;
              if (sc == NP) begin
                strobe_next = 1'b1;
                status_next = ST_OOM;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        if (wptr == hi_word) begin
          strobe_next = 1'b1;
          state_next  = S_IDLE;
        end else begin
          wptr_next  = wptr + 1'b1;
          state_next = S_RD;
        end
      end
      S_FETCH: begin
        ram_raddr  = sc_word;
        fresh_next = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (ffs[5]) begin
          // take the page and keep the word locally for the next page
          ram_we        = 1'b1;
          ram_waddr     = sc_word;
          ram_wdata     = scan_src & ~(32'd1 << ffs[4:0]);
          word_reg_next = ram_wdata;
          fresh_next    = 1'b0;
          sc_next       = take_page;
          strobe_next   = 1'b1;
          phys_next     = 32'(take_page) << PAGE_SHIFT;
          vout_next     = virt;
          last_next     = (cnt == CW'(1));
          virt_next     = virt + PAGE_BYTES;
          cnt_next      = cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state_next = S_IDLE;
          end
        end else if (sc_word == LAST_WORD) begin
          sc_next     = NP;
          strobe_next = 1'b1;
          status_next = ST_OOM;
          state_next  = S_IDLE;
        end else begin
          sc_next    = PW'(sc_word + 1'b1) << 5;
          state_next = S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      sc     <= '0;
      virt   <= VIRT_BASE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      clr    <= clr_next;
      sc     <= sc_next;
      virt   <= virt_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    lo        <= lo_next;
    hi_m1     <= hi_m1_next;
    wptr      <= wptr_next;
    word_reg  <= word_reg_next;
    fresh     <= fresh_next;
    page_addr <= phys_next;
    virt_addr <= vout_next;
    status    <= status_next;
    last      <= last_next;
  end

endmodule

@@ rtl/page_bitmap_allocator_top.sv @@
// Channel   Handshake            Words
// --------  -------------------  ---------------------------------------
// request   start / busy         action, address, size
// result    strobe (one cycle)   page_addr, virt_addr, status, last
//
// Reset, then a sweep that sets every bitmap RAM word to all free, busy high meanwhile.
// A word accepted into the queue reaches the bitmap engine once the engine is idle; a
// reserve then reads and writes back each bitmap word it touches, an allocate fetches
// words from the scan cursor on, taking their free pages in turn; others end in idle.
// Each result leaves the engine through an output register and cannot be stalled.
// busy rises while the two-entry queue in front of the engine is full.
module page_bitmap_allocator_top import pba_pkg::*; #(
  parameter int NUM_PAGES = 32768,
  parameter int MAX_ALLOC_PAGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] address,
  input  logic [31:0] size,
  output logic        strobe,
  output logic [31:0] page_addr,
  output logic [31:0] virt_addr,
  output logic [1:0]  status,
  output logic        last
);

  localparam int PW = $clog2(NUM_PAGES + 1);
  localparam int CW = $clog2(MAX_ALLOC_PAGES + 1);

  pba_head_t     head;
  logic [PW-1:0] head_lo;
  logic [PW-1:0] head_hi;
  logic [CW-1:0] head_cnt;
  logic          pop;
  logic          clearing;

  pba_front #(
    .NUM_PAGES      (NUM_PAGES),
    .MAX_ALLOC_PAGES(MAX_ALLOC_PAGES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .address (address),
    .size    (size),
    .busy    (busy),
    .clearing(clearing),
    .head    (head),
    .head_lo (head_lo),
    .head_hi (head_hi),
    .head_cnt(head_cnt),
    .pop     (pop)
  );

  pba_back #(
    .NUM_PAGES      (NUM_PAGES),
    .MAX_ALLOC_PAGES(MAX_ALLOC_PAGES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .head_lo  (head_lo),
    .head_hi  (head_hi),
    .head_cnt (head_cnt),
    .pop      (pop),
    .clearing (clearing),
    .strobe   (strobe),
    .page_addr(page_addr),
    .virt_addr(virt_addr),
    .status   (status),
    .last     (last)
  );

endmodule

@@ rtl/pba_checker.sv @@
`include "page_bitmap_allocator_top_assert.svh"

module pba_checker import pba_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        strobe,
  input logic [31:0] page_addr,
  input logic [31:0] virt_addr,
  input logic [1:0]  status,
  input logic        last
);

  // error results always close the word's result list
  `PBA_ASSERT_NOW(a_err_last, strobe && (status != ST_OK), last)
  `PBA_ASSERT_NOW(a_err_no_page, strobe && (status != ST_OK), page_addr == 32'd0)
  // a page in the middle of an allocation is page aligned on both sides
  `PBA_ASSERT_NOW(a_mid_aligned, strobe && !last,
                  (status == ST_OK) && (page_addr[11:0] == 12'd0) &&
                  (virt_addr[11:0] == 12'd0))
  // the clearing sweep holds requests off right after reset
  `PBA_ASSERT_NOW(a_clear_busy, $fell(rst), busy && !strobe)
  `PBA_ASSERT_NEXT(a_no_strobe_after_rst, $rose(rst), !strobe)

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .strobe   (strobe),
  .page_addr(page_addr),
  .virt_addr(virt_addr),
  .status   (status),
  .last     (last)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench import pba_pkg::*;;

  localparam int PAGE_COUNT     = 32768;
  localparam int MAX_GRANT      = 64;
  localparam int RANDOM_WORDS   = 145;
  localparam int OPENING_ROWS   = 19;
  localparam int SETTLE_CYCLES  = 100;
  localparam int CYCLE_LIMIT    = 1200000;

  typedef enum logic {
    ACT_RESERVE = 1'b0,
    ACT_ALLOC   = 1'b1
  } action_e;

  typedef struct packed {
    logic [31:0] phys;
    logic [31:0] virt;
    logic [1:0]  code;
    logic        fin;
  } grant_t;

  typedef struct packed {
    action_e     act;
    logic [31:0] addr;
    logic [31:0] sz;
    logic        typed;
    grant_t      want;
  } request_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        action;
  logic [31:0] address;
  logic [31:0] size;
  logic        strobe;
  logic [31:0] page_addr;
  logic [31:0] virt_addr;
  logic [1:0]  status;
  logic        last;

  // allocator image kept by the testbench
  bit          page_is_free [PAGE_COUNT];
  int          scan_ptr;
  logic [31:0] virt_ptr;

  grant_t       new_grants[$];
  grant_t       pending_grants[$];
  grant_t       head_grant;
  request_row_t request_rows[$];

  int mismatches;
  int words_sent;
  int allocs_sent;
  int results_seen;
  int oom_grants;
  int cycle_count;
  int burst_left;

  page_bitmap_allocator_top #(
    .NUM_PAGES(PAGE_COUNT),
    .MAX_ALLOC_PAGES(MAX_GRANT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .address(address),
    .size(size),
    .strobe(strobe),
    .page_addr(page_addr),
    .virt_addr(virt_addr),
    .status(status),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_grants.size());
      $display("FAIL page_bitmap_allocator_top");
      $finish;
    end
  end

  function automatic grant_t make_grant(input logic [31:0] phys, input logic [31:0] virt,
                                        input logic [1:0] code, input logic fin);
    grant_t g;
    g.phys = phys;
    g.virt = virt;
    g.code = code;
    g.fin  = fin;
    return g;
  endfunction

  function automatic request_row_t req_row(input action_e act, input logic [31:0] addr,
                                           input logic [31:0] sz, input logic typed,
                                           input logic [31:0] phys, input logic [31:0] virt,
                                           input logic [1:0] code);
    request_row_t r;
    r.act   = act;
    r.addr  = addr;
    r.sz    = sz;
    r.typed = typed;
    r.want  = make_grant(phys, virt, code, 1'b1);
    return r;
  endfunction

  // Work out the grants one request word causes and update the image.
  task automatic compute_grants(input action_e act, input logic [31:0] addr,
                                input logic [31:0] sz);
    logic [32:0] rounded;
    int          npages;
    int          first_page;
    int          end_page;
    bit          exhausted;
    new_grants.delete();
    rounded   = {1'b0, sz} + 33'd4095;
    npages    = int'(rounded >> PAGE_SHIFT);
    exhausted = 1'b0;
    if (act == ACT_RESERVE) begin
      first_page = int'(addr >> PAGE_SHIFT);
      end_page   = first_page + npages;
      if (end_page > PAGE_COUNT) end_page = PAGE_COUNT;
      for (int p = first_page; p < end_page; p++) page_is_free[p] = 1'b0;
      new_grants.push_back(make_grant(32'd0, 32'd0, ST_OK, 1'b1));
    end else if (npages > MAX_GRANT) begin
      new_grants.push_back(make_grant(32'd0, 32'd0, ST_BIG, 1'b1));
    end else if (npages == 0) begin
      new_grants.push_back(make_grant(32'd0, virt_ptr, ST_OK, 1'b1));
    end else begin
      for (int i = 0; i < npages && !exhausted; i++) begin
        while (scan_ptr < PAGE_COUNT && !page_is_free[scan_ptr]) scan_ptr++;
        if (scan_ptr >= PAGE_COUNT) begin
          scan_ptr  = PAGE_COUNT;
          exhausted = 1'b1;
          oom_grants++;
          new_grants.push_back(make_grant(32'd0, 32'd0, ST_OOM, 1'b1));
        end else begin
          page_is_free[scan_ptr] = 1'b0;
          new_grants.push_back(make_grant(32'(scan_ptr) << PAGE_SHIFT, virt_ptr, ST_OK,
                                          (i + 1 == npages)));
          virt_ptr = virt_ptr + PAGE_BYTES;
        end
      end
    end
  endtask

  task automatic issue_word(input action_e act, input logic [31:0] addr,
                            input logic [31:0] sz, input logic typed, input grant_t want);
    start   <= 1'b1;
    action  <= act;
    address <= addr;
    size    <= sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_grants(act, addr, sz);
    if (typed) pending_grants.push_back(want);
    else foreach (new_grants[k]) pending_grants.push_back(new_grants[k]);
    words_sent++;
    if (act == ACT_ALLOC) allocs_sent++;
  endtask

  task automatic idle_for(input int cycles);
    start   <= 1'b0;
    address <= $urandom;
    size    <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // Open a new burst when the old one is used up, sometimes with no gap.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
    end
    burst_left--;
  endtask

  task automatic drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic walk_rows(input int lo, input int hi);
    for (int r = lo; r < hi; r++) begin
      pace();
      issue_word(request_rows[r].act, request_rows[r].addr, request_rows[r].sz,
                 request_rows[r].typed, request_rows[r].want);
    end
  endtask

  task automatic random_word();
    int          pick;
    int          pages;
    action_e     act;
    logic [31:0] addr;
    logic [31:0] sz;
    pick = $urandom_range(0, 99);
    act  = ACT_ALLOC;
    addr = $urandom;
    if (pick < 45) begin
      pages = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 64);
      sz    = (pages - 1) * 4096 + $urandom_range(1, 4096);
    end else if (pick < 50) begin
      sz = 32'd0;
    end else if (pick < 55) begin
      sz = MAX_GRANT * 4096 + $urandom_range(0, 1);
    end else if (pick < 65) begin
      sz = $urandom_range(32'h0004_0001, 32'hFFFF_FFFF);
    end else if (pick < 85) begin
      // keep in-map reservations low so the scan has room to run
      act  = ACT_RESERVE;
      addr = $urandom_range(0, 32'h01FF_FFFF);
      sz   = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 32'h0004_0000)
                                         : $urandom_range(0, 32'h0040_0000);
    end else begin
      act  = ACT_RESERVE;
      addr = $urandom_range(32'h0800_0000, 32'hFFFF_FFFF);
      sz   = $urandom;
    end
    pace();
    issue_word(act, addr, sz, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h %h %0d %0d",
                 $time, page_addr, virt_addr, status, last);
        mismatches++;
      end else begin
        head_grant = pending_grants.pop_front();
        check_field("page_addr", head_grant.phys, page_addr);
        check_field("virt_addr", head_grant.virt, virt_addr);
        check_field("status", 32'(head_grant.code), 32'(status));
        check_field("last", 32'(head_grant.fin), 32'(last));
      end
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    action      = 1'b0;
    address     = 32'd0;
    size        = 32'd0;
    mismatches  = 0;
    words_sent  = 0;
    allocs_sent = 0;
    results_seen = 0;
    oom_grants  = 0;
    cycle_count = 0;
    burst_left  = 0;
    foreach (page_is_free[p]) page_is_free[p] = 1'b1;
    scan_ptr = 0;
    virt_ptr = VIRT_BASE;

    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h1, 1'b1, 32'h0, VIRT_BASE, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, ONES, 32'h0, 1'b1, 32'h0, 32'hF000_1000, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0004_0000, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0004_0001, 1'b1, 0, 0, ST_BIG));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, ONES, 1'b1, 0, 0, ST_BIG));
    request_rows.push_back(req_row(ACT_RESERVE, 32'h0, 32'h0, 1'b1, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_RESERVE, ONES, ONES, 1'b1, 0, 0, ST_OK));
    // straddles the top of the map: only the last page sticks
    request_rows.push_back(req_row(ACT_RESERVE, 32'h07FF_F000, ONES, 1'b1, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_RESERVE, 32'h0004_1FFF, 32'h2, 1'b1, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_RESERVE, 32'h0004_5800, 32'h1000, 1'b1, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h3000, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h1001, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_RESERVE, 32'h0010_0000, 32'h0010_0000, 1'b1, 0, 0,
                                   ST_OK));
    request_rows.push_back(req_row(ACT_RESERVE, 32'h0, 32'h0001_0000, 1'b1, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0FFF, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0004_0000, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0004_0000, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0004_0000, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h1234_5678, 32'h1000, 1'b0, 0, 0, ST_OK));
    // closing rows: fill the map, then run the scan off its end
    request_rows.push_back(req_row(ACT_RESERVE, 32'h0, 32'h07FF_C000, 1'b1, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h8000, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h1000, 1'b1, 0, 0, ST_OOM));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0, 1'b0, 0, 0, ST_OK));
    request_rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0004_0001, 1'b1, 0, 0, ST_BIG));
    request_rows.push_back(req_row(ACT_RESERVE, 32'h2000, 32'h3000, 1'b1, 0, 0, ST_OK));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    walk_rows(0, OPENING_ROWS);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      random_word();
      if (n == RANDOM_WORDS / 2) drain_pause();
    end
    drain_pause();
    walk_rows(OPENING_ROWS, request_rows.size());

    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Drove %0d request words (%0d allocate, %0d reserve), checked %0d results.",
             words_sent, allocs_sent, words_sent - allocs_sent, results_seen);
    $display("Out-of-memory endings: %0d, scan stopped at page %0d.", oom_grants, scan_ptr);
    if (mismatches == 0) begin
      $display("PASS page_bitmap_allocator_top");
    end else begin
      $display("FAIL page_bitmap_allocator_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_ram.sv
rtl/pba_front.sv
rtl/pba_back.sv
rtl/page_bitmap_allocator_top.sv
rtl/pba_checker.sv
verif/testbench.sv
